// ----- sv/mlps_pkg.sv -----
// Shared types, constants and tables of the two-layer sigmoid perceptron.
package mlps_pkg;

    localparam int HIDDEN_DEF       = 5;
    localparam int WEIGHT_DEPTH_DEF = 64;
    localparam int HIDDEN_MAX       = 16;
    localparam int NIN              = 4;

    localparam int SEL_W      = $clog2(HIDDEN_MAX + 1);
    localparam int NEU_W      = $clog2(HIDDEN_MAX);
    localparam int ACC_W      = 40;
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 24;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic LAYER_HID = 1'b0;
    localparam logic LAYER_OUT = 1'b1;

    // Output neuron roles.
    localparam logic [NEU_W-1:0] OUT_ADV   = NEU_W'(0);
    localparam logic [NEU_W-1:0] OUT_LEFT  = NEU_W'(1);
    localparam logic [NEU_W-1:0] OUT_SHOOT = NEU_W'(3);
    localparam logic [NEU_W-1:0] OUT_FOV   = NEU_W'(4);

    // Position of the fov input among the first-layer inputs.
    localparam logic [SEL_W-1:0] SEL_FOV = SEL_W'(NIN - 1);

    localparam logic signed [15:0] Q12_ONE   = 16'sd4096;
    localparam logic signed [15:0] Q12_M_ONE = -16'sd4096;
    localparam logic [12:0]        HALF_Q12  = 13'd2048;
    localparam logic [12:0]        ONE_Q12   = 13'd4096;
    localparam logic [12:0]        LOG2E_Q12 = 13'd5909;

    // 2^(-k/16) in Q16, k = 0..16.
    localparam logic [16:0] EXP2_TAB [17] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    typedef struct packed {
        logic             valid;
        logic             layer;
        logic [SEL_W-1:0] sel;
        logic             last;
        logic             zero;
        logic [NEU_W-1:0] neuron;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic act_done;
        logic out_full;
    } t_stat;

    typedef struct packed {
        logic        advance;
        logic        turn_left;
        logic        turn_right;
        logic        shoot;
        logic [12:0] fov_mult;
    } t_result;

endpackage

// ----- sv/two_layer_sigmoid_mlp_inference_top.sv -----
// Top level of the two-layer sigmoid perceptron with loadable weight memory.
//
//  Channel  Dir  Transfer                       Payload
//  s_axis   in   weight write or evaluate       tuser = op, tdata = weight and network inputs
//  m_axis   out  one decision per evaluate      tdata = four flags and fov_mult
//
// A weight write leaves the block ready at once.
// An evaluate runs each of the 2*HIDDEN neurons through the one shared
// multiply-accumulate (one weight per cycle), then through the weight read,
// product and accumulator registers into the sigmoid unit, whose 13-step
// divider dominates. The result becomes valid in the cycle after the input is
// ready again. Synchronous active-low reset clears the control state; the
// weight memory is undefined until written. A stalled result stays in the
// output register; weight writes go on, and an evaluate that finishes
// meanwhile waits with the input not ready.
module two_layer_sigmoid_mlp_inference_top #(
    parameter int HIDDEN       = mlps_pkg::HIDDEN_DEF,
    parameter int WEIGHT_DEPTH = mlps_pkg::WEIGHT_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [5:0] weight_index, [21:6] weight_value, [22] in_fov, [23] bullet_in_fov,
    // [24] can_shoot, [40:25] fov, [47:41] zero
    input  logic [mlps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] op
    input  logic [mlps_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] advance, [1] turn_left, [2] turn_right, [3] shoot, [16:4] fov_mult,
    // [23:17] zero
    output logic [mlps_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import mlps_pkg::*;

    logic                     w_accept;
    logic                     w_ready;
    t_cmd                     w_cmd;
    t_stat                    w_stat;
    logic [$clog2(WEIGHT_DEPTH)-1:0] w_rd_addr;
    t_result                  w_res;

    assign w_accept = s_axis_tvalid && w_ready;

    mlps_ctrl #(
        .HIDDEN       (HIDDEN),
        .WEIGHT_DEPTH (WEIGHT_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_accept),
        .i_op        (s_axis_tuser[0]),
        .o_in_ready  (w_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr)
    );

    mlps_datapath #(
        .HIDDEN       (HIDDEN),
        .WEIGHT_DEPTH (WEIGHT_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_accept     (w_accept),
        .i_op            (s_axis_tuser[0]),
        .i_weight_index  (s_axis_tdata[5:0]),
        .i_weight_value  ($signed(s_axis_tdata[21:6])),
        .i_in_fov        (s_axis_tdata[22]),
        .i_bullet_in_fov (s_axis_tdata[23]),
        .i_can_shoot     (s_axis_tdata[24]),
        .i_fov           ($signed(s_axis_tdata[40:25])),
        .i_cmd           (w_cmd),
        .i_rd_addr       (w_rd_addr),
        .i_m_ready       (m_axis_tready),
        .o_stat          (w_stat),
        .o_m_valid       (m_axis_tvalid),
        .o_result        (w_res)
    );

    assign s_axis_tready = w_ready;
    assign m_axis_tdata  = {7'd0, w_res.fov_mult, w_res.shoot, w_res.turn_right,
                            w_res.turn_left, w_res.advance};

endmodule

// ----- sv/mlps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mlps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/mlps_sigmoid.sv -----
// Multi-cycle sigmoid unit: exp2 table with interpolation and a radix-2 divider.
module mlps_sigmoid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_x,
    output logic               o_done,
    output logic [12:0]        o_y
);
    import mlps_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_T, ST_M, ST_PREP, ST_DIV} t_state;

    t_state             r_state;
    logic signed [15:0] r_x;
    logic [15:0]        r_t;
    logic [16:0]        r_m;
    logic [3:0]         r_ip;
    logic [28:0]        r_rem;
    logic [29:0]        r_div;
    logic [12:0]        r_q;
    logic [3:0]         r_cnt;
    logic               r_done;
    logic [12:0]        r_y;

    logic [16:0] w_abs;
    logic [29:0] w_tsum;
    logic [4:0]  w_k0;
    logic [4:0]  w_k1;
    logic [16:0] w_tk;
    logic [16:0] w_diff;
    logic [19:0] w_dprod;
    logic [16:0] w_m;
    logic [16:0] w_e;
    logic [17:0] w_d;
    logic        w_ge;
    logic [12:0] w_qf;

    always_comb begin
        w_abs   = r_x[15] ? (17'd0 - {1'b1, r_x}) : {1'b0, r_x};
        // |x| * log2(e), rounded to Q12.
        w_tsum  = w_abs * LOG2E_Q12 + 30'd2048;
        w_k0    = {1'b0, r_t[11:8]};
        w_k1    = w_k0 + 5'd1;
        w_tk    = EXP2_TAB[w_k0];
        w_diff  = w_tk - EXP2_TAB[w_k1];
        w_dprod = w_diff[11:0] * r_t[7:0];
        w_m     = w_tk - 17'((w_dprod + 20'd128) >> 8);
        w_e     = r_m >> r_ip;
        w_d     = 18'd65536 + {1'b0, w_e};
        w_ge    = ({1'b0, r_rem} >= r_div);
        w_qf    = {r_q[11:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == ST_DIV) && (r_cnt == 4'd0);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_x;
                        r_state <= ST_T;
                    end
                end
                ST_T: begin
                    r_t     <= w_tsum[27:12];
                    r_state <= ST_M;
                end
                ST_M: begin
                    r_m     <= w_m;
                    r_ip    <= r_t[15:12];
                    r_state <= ST_PREP;
                end
                ST_PREP: begin
                    // Rounded quotient 2^28 / d, computed as floor((2^28 + d/2) / d).
                    r_rem   <= 29'h1000_0000 + 29'(w_d >> 1);
                    r_div   <= {w_d, 12'd0};
                    r_q     <= '0;
                    r_cnt   <= 4'd12;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_ge) begin
                        r_rem <= r_rem - r_div[28:0];
                    end
                    r_q   <= w_qf;
                    r_div <= r_div >> 1;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_y     <= r_x[15] ? (ONE_Q12 - w_qf) : w_qf;
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;

endmodule

// ----- sv/mlps_ctrl.sv -----
// Sequencer that walks the weights of both layers and issues datapath commands.
module mlps_ctrl #(
    parameter int HIDDEN       = mlps_pkg::HIDDEN_DEF,
    parameter int WEIGHT_DEPTH = mlps_pkg::WEIGHT_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_accept,
    input  logic                            i_op,
    output logic                            o_in_ready,
    input  mlps_pkg::t_stat                 i_stat,
    output mlps_pkg::t_cmd                  o_cmd,
    output logic [$clog2(WEIGHT_DEPTH)-1:0] o_rd_addr
);
    import mlps_pkg::*;

    localparam int WC    = HIDDEN * (NIN + 1) + HIDDEN * (HIDDEN + 1);
    localparam int CW    = $clog2(WC + 1);
    localparam int AW    = $clog2(WEIGHT_DEPTH);
    localparam int CNT_W = (CW > AW) ? CW : AW;

    localparam logic [NEU_W-1:0] NEU_LAST = NEU_W'(HIDDEN - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [AW-1:0]     r_rd_addr;
    logic              r_layer;
    logic [NEU_W-1:0]  r_neu;
    logic [SEL_W-1:0]  r_term;
    logic [CNT_W-1:0]  r_addr;

    logic [SEL_W-1:0] w_nin;
    logic             w_last;
    logic             w_zero;

    always_comb begin
        w_nin  = (r_layer == LAYER_OUT) ? SEL_W'(HIDDEN) : SEL_W'(NIN);
        w_last = (r_term == w_nin);
        // Positions past the end of the memory read as zero.
        w_zero = (32'(r_addr) >= 32'(WEIGHT_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cmd   <= '0;
            r_layer <= LAYER_HID;
            r_neu   <= '0;
            r_term  <= '0;
            r_addr  <= '0;
        end else begin
            r_cmd.valid    <= (r_state == ST_ISSUE);
            r_cmd.out_load <= (r_state == ST_DONE) && !i_stat.out_full;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_accept && (i_op == OP_EVAL)) begin
                        r_layer <= LAYER_HID;
                        r_neu   <= '0;
                        r_term  <= '0;
                        r_addr  <= '0;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    r_cmd.layer  <= r_layer;
                    r_cmd.sel    <= r_term;
                    r_cmd.last   <= w_last;
                    r_cmd.zero   <= w_zero;
                    r_cmd.neuron <= r_neu;
                    r_rd_addr    <= r_addr[AW-1:0];
                    r_addr       <= r_addr + 1'b1;
                    if (w_last) begin
                        r_term  <= '0;
                        r_state <= ST_WAIT;
                    end else begin
                        r_term <= r_term + 1'b1;
                    end
                end
                ST_WAIT: begin
                    if (i_stat.act_done) begin
                        if (r_neu == NEU_LAST) begin
                            r_neu <= '0;
                            if (r_layer == LAYER_OUT) begin
                                r_state <= ST_DONE;
                            end else begin
                                r_layer <= LAYER_OUT;
                                r_state <= ST_ISSUE;
                            end
                        end else begin
                            r_neu   <= r_neu + 1'b1;
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                ST_DONE: begin
                    if (!i_stat.out_full) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_in_ready = i_rst_n && (r_state == ST_IDLE);
    assign o_cmd      = r_cmd;
    assign o_rd_addr  = r_rd_addr;

endmodule

// ----- sv/mlps_datapath.sv -----
// Weight memory, shared multiply-accumulate, sigmoid and result registers.
module mlps_datapath #(
    parameter int HIDDEN       = mlps_pkg::HIDDEN_DEF,
    parameter int WEIGHT_DEPTH = mlps_pkg::WEIGHT_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_accept,
    input  logic                            i_op,
    input  logic [5:0]                      i_weight_index,
    input  logic signed [15:0]              i_weight_value,
    input  logic                            i_in_fov,
    input  logic                            i_bullet_in_fov,
    input  logic                            i_can_shoot,
    input  logic signed [15:0]              i_fov,
    input  mlps_pkg::t_cmd                  i_cmd,
    input  logic [$clog2(WEIGHT_DEPTH)-1:0] i_rd_addr,
    input  logic                            i_m_ready,
    output mlps_pkg::t_stat                 o_stat,
    output logic                            o_m_valid,
    output mlps_pkg::t_result               o_result
);
    import mlps_pkg::*;

    localparam int WC = HIDDEN * (NIN + 1) + HIDDEN * (HIDDEN + 1);
    localparam int AW = $clog2(WEIGHT_DEPTH);
    localparam int NW = $clog2(HIDDEN);

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2048);
    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(32768);

    logic                     w_we;
    logic [15:0]              w_rdata;
    logic [2:0]               r_flags;
    logic signed [15:0]       r_fov;
    t_cmd                     r_c1;
    t_cmd                     r_c2;
    logic signed [31:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_sum_go;
    logic                     r_dst_layer;
    logic [NEU_W-1:0]         r_dst_neu;
    logic [12:0]              r_hid [HIDDEN];
    logic                     r_o_adv;
    logic                     r_o_left;
    logic                     r_o_shoot;
    logic [12:0]              r_o_fov;
    logic                     r_m_valid;
    t_result                  r_res;

    logic signed [15:0]       w_opnd;
    logic signed [15:0]       w_wt;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_shf;
    logic signed [15:0]       w_sat;
    logic                     w_sig_done;
    logic [12:0]              w_y;
    logic                     w_y_half;

    assign w_we = i_in_accept && (i_op == OP_WRITE)
               && (32'(i_weight_index) < 32'(WC))
               && (32'(i_weight_index) < 32'(WEIGHT_DEPTH));

    mlps_ram #(
        .WIDTH (16),
        .DEPTH (WEIGHT_DEPTH)
    ) u_wmem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_weight_index)),
        .i_wdata (i_weight_value),
        .i_re    (i_cmd.valid),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_wt = r_c1.zero ? 16'sd0 : $signed(w_rdata);
        if (r_c1.last) begin
            w_opnd = Q12_ONE;
        end else if (r_c1.layer == LAYER_OUT) begin
            w_opnd = $signed({3'b000, r_hid[r_c1.sel[NW-1:0]]});
        end else if (r_c1.sel == SEL_FOV) begin
            w_opnd = r_fov;
        end else begin
            w_opnd = r_flags[r_c1.sel[1:0]] ? Q12_ONE : Q12_M_ONE;
        end
        // Round half up to Q4.12 and saturate.
        w_rnd = r_acc + RND_HALF;
        w_shf = w_rnd >>> 12;
        if (w_shf > SAT_HI) begin
            w_sat = 16'sh7fff;
        end else if (w_shf < SAT_LO) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = w_shf[15:0];
        end
        w_y_half = (w_y >= HALF_Q12);
    end

    mlps_sigmoid u_sig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sum_go),
        .i_x     (w_sat),
        .o_done  (w_sig_done),
        .o_y     (w_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1      <= '0;
            r_c2      <= '0;
            r_sum_go  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_c1     <= i_cmd;
            r_c2     <= r_c1;
            r_sum_go <= r_c2.valid && r_c2.last;
            if (i_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept && (i_op == OP_EVAL)) begin
            r_flags <= {i_can_shoot, i_bullet_in_fov, i_in_fov};
            r_fov   <= i_fov;
        end
        r_prod <= w_opnd * w_wt;
        if (r_c2.valid) begin
            r_acc <= (r_c2.sel == '0) ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
            if (r_c2.last) begin
                r_dst_layer <= r_c2.layer;
                r_dst_neu   <= r_c2.neuron;
            end
        end
        if (w_sig_done) begin
            if (r_dst_layer == LAYER_HID) begin
                r_hid[r_dst_neu[NW-1:0]] <= w_y;
            end else begin
                unique case (r_dst_neu)
                    OUT_ADV:   r_o_adv   <= w_y_half;
                    OUT_LEFT:  r_o_left  <= w_y_half;
                    OUT_SHOOT: r_o_shoot <= w_y_half;
                    OUT_FOV:   r_o_fov   <= w_y + HALF_Q12;
                    default: ;
                endcase
            end
        end
        if (i_cmd.out_load) begin
            r_res.advance    <= r_o_adv;
            r_res.turn_left  <= r_o_left;
            r_res.turn_right <= !r_o_left;
            r_res.shoot      <= r_o_shoot;
            r_res.fov_mult   <= r_o_fov;
        end
    end

    assign o_stat.act_done = w_sig_done;
    assign o_stat.out_full = r_m_valid && !i_m_ready;
    assign o_m_valid       = r_m_valid;
    assign o_result        = r_res;

endmodule

// ----- sv/mlps_checker.sv -----
// Port-level assertions for the perceptron top level, bound to it.
module mlps_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [mlps_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mlps_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import mlps_pkg::*;

    // A stalled result keeps its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_turn_inverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2] == !m_axis_tdata[1]))
        else $error("turn_right is not the inverse of turn_left");

    a_fov_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:4] >= 13'd2048) && (m_axis_tdata[16:4] <= 13'd6144))
        else $error("fov_mult outside its range");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // An evaluate keeps the input not ready while it runs.
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_EVAL) |=> !s_axis_tready)
        else $error("input ready right after an evaluate transfer");

endmodule

bind two_layer_sigmoid_mlp_inference_top mlps_checker u_chk (.*);
